[design/krt_pkg.sv]
`default_nettype none

package krt_pkg;

    // Table geometry.
    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of one input word and one result word.
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int STAT_W   = 2;
    localparam int SLOT_W   = 7;
    localparam int TOTAL_W  = 8;

    localparam int IN_BITS  = CMD_W + KEY_W + PAY_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STAT_W + SLOT_W + PAY_W + TOTAL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // Read address source for both table memories.
    typedef enum logic [1:0] {
        RD_SCAN,
        RD_HIT,
        RD_LAST
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;        // latch the accepted word, restart the scan
        logic              scan;        // issue the next scan read
        logic              hold_pos;    // capture the matching slot
        rd_sel_t           rd_sel;
        logic              wr_key;
        logic              wr_pay;
        logic              wr_move;     // write data comes from the memories
        logic              wr_at_count; // write at the append slot, else at pos
        logic              count_inc;
        logic              count_dec;
        logic              cap_found;   // capture the looked-up payload
        logic              res_load;    // load the result register
        logic [STAT_W-1:0] res_status;
    } krt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             hit;
        logic             scan_end;
        logic             out_free;
    } krt_stat_t;

endpackage

`default_nettype wire

[design/krt_ram.sv]
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/krt_datapath.sv]
`default_nettype none

module krt_datapath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [krt_pkg::IN_W-1:0]  in_word,
    input  wire logic                      m_tready,
    output logic                           m_tvalid,
    output logic      [krt_pkg::OUT_W-1:0] m_tdata,
    input  wire krt_pkg::krt_cmd_t         ctl,
    output krt_pkg::krt_stat_t             stat
);

    import krt_pkg::*;

    // Control registers.
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    logic [CMD_W-1:0]  cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PAY_W-1:0]  pay_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [PAY_W-1:0]  found_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic              issue;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    logic [KEY_W-1:0]  key_rdata;
    logic [PAY_W-1:0]  pay_rdata;
    logic [KEY_W-1:0]  key_wdata;
    logic [PAY_W-1:0]  pay_wdata;
    logic [SLOT_W-1:0] res_slot;

    assign issue    = rd_idx_reg < count_reg;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        case (ctl.rd_sel)
            RD_HIT:  raddr = cmp_idx_reg;
            RD_LAST: raddr = last_idx;
            default: raddr = rd_idx_reg[IDX_W-1:0];
        endcase
    end

    assign waddr     = ctl.wr_at_count ? count_reg[IDX_W-1:0] : pos_reg;
    assign key_wdata = ctl.wr_move ? key_rdata : key_reg;
    assign pay_wdata = ctl.wr_move ? pay_rdata : pay_reg;

    krt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .clk   (clk),
        .we    (ctl.wr_key),
        .waddr (waddr),
        .wdata (key_wdata),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    krt_ram #(.WIDTH(PAY_W), .DEPTH(CAPACITY)) u_pay_ram (
        .clk   (clk),
        .we    (ctl.wr_pay),
        .waddr (waddr),
        .wdata (pay_wdata),
        .raddr (raddr),
        .rdata (pay_rdata)
    );

    always_comb
    begin
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        m_tvalid_next  = m_tvalid_reg;

        if (ctl.load)
        begin
            rd_idx_next = '0;
        end
        else if (ctl.scan)
        begin
            cmp_valid_next = issue;
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
        end

        if (ctl.count_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.count_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (ctl.res_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Failed operations report slot zero.
    assign res_slot = (ctl.res_status == ST_OK) ? SLOT_W'(pos_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= in_word[CMD_W-1:0];
            key_reg   <= in_word[CMD_W +: KEY_W];
            pay_reg   <= in_word[CMD_W + KEY_W +: PAY_W];
            found_reg <= '0;
        end
        if (ctl.scan)
        begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (ctl.hold_pos)
        begin
            pos_reg <= cmp_idx_reg;
        end
        else if (ctl.wr_at_count)
        begin
            pos_reg <= count_reg[IDX_W-1:0];
        end
        if (ctl.cap_found)
        begin
            found_reg <= pay_rdata;
        end
        if (ctl.res_load)
        begin
            m_tdata_reg <= OUT_W'({TOTAL_W'(count_reg), found_reg, res_slot, ctl.res_status});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.cmd      = cmd_reg;
    assign stat.full     = count_reg >= CNT_W'(CAPACITY);
    assign stat.empty    = count_reg == '0;
    assign stat.hit      = cmp_valid_reg && (key_rdata == key_reg);
    assign stat.scan_end = cmp_valid_reg && (cmp_idx_reg == last_idx);
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

[design/krt_ctrl.sv]
`default_nettype none

module krt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire krt_pkg::krt_stat_t stat,
    output krt_pkg::krt_cmd_t       ctl
);

    import krt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_LOOK,
        S_UPDT,
        S_MOVE,
        S_INS,
        S_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] status_reg, status_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        ctl         = '0;
        ctl.rd_sel  = RD_SCAN;
        ctl.res_status = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (stat.cmd == CMD_INSERT && stat.full)
                begin
                    status_next = ST_FULL;
                    state_next  = S_RESULT;
                end
                else if (stat.empty)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = (stat.cmd == CMD_INSERT) ? S_INS : S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            // One slot is read per cycle; its key is compared in the following cycle.
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    ctl.hold_pos = 1'b1;
                    status_next  = ST_OK;
                    case (stat.cmd)
                        CMD_INSERT:
                        begin
                            status_next = ST_DUPLICATE;
                            state_next  = S_RESULT;
                        end
                        CMD_LOOKUP:
                        begin
                            ctl.rd_sel = RD_HIT;
                            state_next = S_LOOK;
                        end
                        CMD_UPDATE:
                        begin
                            state_next = S_UPDT;
                        end
                        default:
                        begin
                            ctl.rd_sel = RD_LAST;
                            state_next = S_MOVE;
                        end
                    endcase
                end
                else if (stat.scan_end)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = (stat.cmd == CMD_INSERT) ? S_INS : S_RESULT;
                end
                else
                begin
                    ctl.scan = 1'b1;
                end
            end

            S_LOOK:
            begin
                ctl.cap_found = 1'b1;
                state_next    = S_RESULT;
            end

            S_UPDT:
            begin
                ctl.wr_pay = 1'b1;
                state_next = S_RESULT;
            end

            // The last record fills the hole left by the deleted one.
            S_MOVE:
            begin
                ctl.wr_key    = 1'b1;
                ctl.wr_pay    = 1'b1;
                ctl.wr_move   = 1'b1;
                ctl.count_dec = 1'b1;
                state_next    = S_RESULT;
            end

            S_INS:
            begin
                ctl.wr_key      = 1'b1;
                ctl.wr_pay      = 1'b1;
                ctl.wr_at_count = 1'b1;
                ctl.count_inc   = 1'b1;
                status_next     = ST_OK;
                state_next      = S_RESULT;
            end

            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

[design/keyed_record_table.sv]
// Keyed record table: up to 128 records, each a unique 32-bit key with a
// 32-bit payload, kept unsorted in two single-port-write table memories.
// Input words on the s_ channel carry a command (insert, lookup, update or
// delete), a key and a payload. Every input word yields exactly one result
// word on the m_ channel: a status, the slot touched, the payload found by a
// lookup and the number of occupied slots after the operation.
// The scan reads one slot per cycle through the key memory read port. A
// word on an empty table, or an insert into a full one, skips the scan.
// The worst case is a hit in the last slot of a full table. The next word
// is accepted in the cycle after the result is loaded. One word is in
// flight at a time.
// Reset empties the table at once; no clearing pass runs, as slots at or
// above the occupied count are never read.
// The result sits in an output register, so the next input word is accepted
// while the previous result waits. If the receiver stalls, the finished
// result is held and the block waits before loading the next one.
`default_nettype none

module keyed_record_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Input words.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // From bit 0 up: command[1:0], key[31:0], payload[31:0], zero padding.
    input  wire logic [krt_pkg::IN_W-1:0]  s_tdata,
    // Result words.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // From bit 0 up: status[1:0], slot[6:0], found_payload[31:0],
    // entry_total[7:0], zero padding.
    output logic      [krt_pkg::OUT_W-1:0] m_tdata
);

    import krt_pkg::*;

    krt_cmd_t  ctl;
    krt_stat_t stat;

    krt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    krt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .ctl      (ctl),
        .stat     (stat)
    );

endmodule

`default_nettype wire
